FILE: rtl/fiscal_week_date_code_decoder_assert.svh
// ----------------------------------------------------------------------------
// Fiscal week date code decoder assertion macros
// Shared property forms for the checker; the enclosing scope supplies clk
// and rst_n.
// ----------------------------------------------------------------------------
`ifndef FISCAL_WEEK_DATE_CODE_DECODER_ASSERT_SVH
`define FISCAL_WEEK_DATE_CODE_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define FWDC_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwdc: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define FWDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwdc: next-cycle check failed");

`endif

FILE: rtl/fwdc_pkg.sv
// ----------------------------------------------------------------------------
// Fiscal week date code decoder package
// Calendar constants, stage payload types and small helper functions.
// ----------------------------------------------------------------------------
package fwdc_pkg;

  // Year codes above the pivot fall in the 1900s
  localparam int unsigned YEAR_BASE  = 1980;
  localparam int unsigned PIVOT      = 80;
  localparam int unsigned CENT_LO    = 1899;
  localparam int unsigned CENT_HI    = 1999;

  // July 1 of the base year is a Tuesday (Monday = 0)
  localparam int unsigned BASE_WD    = 1;
  localparam int unsigned SAT        = 5;
  localparam int unsigned SUN        = 6;

  // Days from March 1 to July 1
  localparam int unsigned MAR_TO_JUL = 122;
  localparam int unsigned DAYS_YEAR  = 365;

  // Code lengths that carry a date
  localparam logic [3:0]  LEN_SHORT  = 4'd4;
  localparam logic [3:0]  LEN_LONG   = 4'd5;

  // Month index counted from March; January is index 10
  localparam logic [3:0]  MI_JAN     = 4'd10;
  localparam int unsigned NUM_MONTHS = 12;

  typedef logic [6:0]  yidx_t;   // year minus base year, 0..99
  typedef logic [10:0] dnum_t;   // days from March 1 of the code year
  typedef logic [8:0]  doy_t;    // day within a March-based year

  // Word passed from the front stages to the date conversion stages
  typedef struct packed {
    logic  len_ok;
    yidx_t yidx;
    dnum_t dnum;
  } span_t;

  // Remainder by seven of a 7-bit value via reciprocal and one correction
  function automatic logic [2:0] mod7(input logic [6:0] v);
    logic [12:0] prod;
    logic [4:0]  q;
    logic [6:0]  r;
    prod = 13'(v) * 13'd36;
    q    = prod[12:8];
    r    = v - 7'(7'(q) * 7'd7);
    if (r >= 7'd7) begin
      r = r - 7'd7;
    end
    return r[2:0];
  endfunction

  // Leap test for base-relative year with low bits p, j years ahead
  function automatic logic leap_ahead(input logic [1:0] p, input logic [1:0] j);
    logic [1:0] s;
    s = p + j;
    return (s == 2'd0);
  endfunction

  // First day of each month within a March-based year
  function automatic doy_t month_start(input logic [3:0] mi);
    doy_t s;
    case (mi)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/fwdc_date_conv.sv
// ----------------------------------------------------------------------------
// Fiscal week date code decoder: day number to calendar date
// Two register stages: split off whole March-based years, then find the
// month and day. The second stage is the block's output register.
// ----------------------------------------------------------------------------
module fwdc_date_conv (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fwdc_pkg::span_t   in_span,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_valid_res,
  output logic [11:0]       out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day
);

  // Year split stage
  logic                 c4_v_r;
  logic                 c4_ok_r;
  fwdc_pkg::yidx_t      c4_yidx_r;
  logic [1:0]           c4_nyr_r;
  fwdc_pkg::doy_t       c4_doy_r;
  logic [1:0]           c4_nyr_nxt;
  fwdc_pkg::doy_t       c4_doy_nxt;
  logic                 c4_rdy;

  // Output stage
  logic                 out_valid_r;
  logic                 out_res_r;
  logic [11:0]          out_year_r;
  logic [3:0]           out_month_r;
  logic [4:0]           out_day_r;
  logic [11:0]          out_year_nxt;
  logic [3:0]           out_month_nxt;
  logic [4:0]           out_day_nxt;
  logic                 c5_rdy;

  // Year split working signals
  logic [1:0]           p;
  logic                 l1, l2, l3;
  fwdc_pkg::dnum_t      cum1, cum2, cum3;

  // Month search working signals
  logic [3:0]           mi;
  fwdc_pkg::doy_t       dom;

  // Each stage loads when empty or when the next one moves
  assign c5_rdy   = !out_valid_r || out_ready;
  assign c4_rdy   = !c4_v_r || c5_rdy;
  assign in_ready = c4_rdy;

  // Lengths of the next three March-based years
  always_comb begin
    p    = in_span.yidx[1:0];
    l1   = fwdc_pkg::leap_ahead(p, 2'd1);
    l2   = fwdc_pkg::leap_ahead(p, 2'd2);
    l3   = fwdc_pkg::leap_ahead(p, 2'd3);
    cum1 = 11'(fwdc_pkg::DAYS_YEAR) + 11'(l1);
    cum2 = 11'(2 * fwdc_pkg::DAYS_YEAR) + 11'(l1) + 11'(l2);
    cum3 = 11'(3 * fwdc_pkg::DAYS_YEAR) + 11'(l1) + 11'(l2) + 11'(l3);
  end

  // Drop whole years off the day number
  always_comb begin
    if (in_span.dnum >= cum3) begin
      c4_nyr_nxt = 2'd3;
      c4_doy_nxt = 9'(in_span.dnum - cum3);
    end else if (in_span.dnum >= cum2) begin
      c4_nyr_nxt = 2'd2;
      c4_doy_nxt = 9'(in_span.dnum - cum2);
    end else if (in_span.dnum >= cum1) begin
      c4_nyr_nxt = 2'd1;
      c4_doy_nxt = 9'(in_span.dnum - cum1);
    end else begin
      c4_nyr_nxt = 2'd0;
      c4_doy_nxt = 9'(in_span.dnum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_v_r <= 1'b0;
    end else if (c4_rdy) begin
      c4_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c4_rdy) begin
      c4_ok_r   <= in_span.len_ok;
      c4_yidx_r <= in_span.yidx;
      c4_nyr_r  <= c4_nyr_nxt;
      c4_doy_r  <= c4_doy_nxt;
    end
  end

  // Find the month by comparing against every month start
  always_comb begin
    mi = 4'd0;
    for (int i = 1; i < fwdc_pkg::NUM_MONTHS; i++) begin
      if (c4_doy_r >= fwdc_pkg::month_start(4'(i))) begin
        mi = 4'(i);
      end
    end
    dom = c4_doy_r - fwdc_pkg::month_start(mi) + 9'd1;
  end

  // Form the calendar fields; a bad length gives all zeros
  always_comb begin
    if (c4_ok_r) begin
      out_day_nxt   = dom[4:0];
      out_month_nxt = (mi < fwdc_pkg::MI_JAN) ? (mi + 4'd3) : (mi - 4'd9);
      out_year_nxt  = 12'(fwdc_pkg::YEAR_BASE) + 12'(c4_yidx_r) + 12'(c4_nyr_r)
                    + 12'(mi >= fwdc_pkg::MI_JAN);
    end else begin
      out_day_nxt   = '0;
      out_month_nxt = '0;
      out_year_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c5_rdy) begin
      out_valid_r <= c4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c5_rdy) begin
      out_res_r   <= c4_ok_r;
      out_year_r  <= out_year_nxt;
      out_month_r <= out_month_nxt;
      out_day_r   <= out_day_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;
  assign out_year      = out_year_r;
  assign out_month     = out_month_r;
  assign out_day       = out_day_r;

endmodule

FILE: rtl/fiscal_week_date_code_decoder.sv
// ----------------------------------------------------------------------------
// Fiscal week date code decoder
// Turns a 4- or 5-digit fiscal week date code into a calendar date.
// ----------------------------------------------------------------------------
//
//   channel  handshake              word
//   -------  ---------------------  -----------------------------------------
//   in       in_valid / in_ready    code length and five 4-bit digits
//   out      out_valid / out_ready  length flag, year, month, day
//
// A word passes through five register stages on its way from acceptance
// to out_valid. One word is taken each cycle while out_ready stays high.
// A stall holds every occupied stage; empty stages keep filling, so up to
// five words are held. Reset clears only the stage valid bits.
//
module fiscal_week_date_code_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_code_length,
  input  logic [3:0]  in_digit_a,
  input  logic [3:0]  in_digit_b,
  input  logic [3:0]  in_digit_c,
  input  logic [3:0]  in_digit_d,
  input  logic [3:0]  in_digit_e,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day
);

  // Digit assembly stage
  logic              s1_v_r;
  logic              s1_ok_r;
  logic [7:0]        s1_yc_r;
  logic [7:0]        s1_week_r;
  logic [3:0]        s1_day_r;
  logic              s1_ok_nxt;
  logic [7:0]        s1_yc_nxt;
  logic [7:0]        s1_week_nxt;
  logic [3:0]        s1_day_nxt;
  logic              s1_rdy;

  // Year index and raw day offset stage
  logic              s2_v_r;
  logic              s2_ok_r;
  fwdc_pkg::yidx_t   s2_yidx_r;
  logic [6:0]        s2_wsum_r;
  logic [10:0]       s2_rel_r;
  fwdc_pkg::yidx_t   s2_yidx_nxt;
  logic [6:0]        s2_wsum_nxt;
  logic [10:0]       s2_rel_nxt;
  logic              s2_rdy;

  // Weekday adjust stage
  logic              s3_v_r;
  fwdc_pkg::span_t   s3_span_r;
  fwdc_pkg::span_t   s3_span_nxt;
  logic              s3_rdy;
  logic [2:0]        wd;
  logic [2:0]        adj;

  logic              conv_rdy;

  // Each stage loads when empty or when the next one moves
  assign s3_rdy   = !s3_v_r || conv_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // Assemble year code, week and day from the digits
  always_comb begin
    s1_ok_nxt = (in_code_length == fwdc_pkg::LEN_SHORT) ||
                (in_code_length == fwdc_pkg::LEN_LONG);
    s1_yc_nxt = 8'(in_digit_a) * 8'd10 + 8'(in_digit_b);
    if (in_code_length == fwdc_pkg::LEN_LONG) begin
      s1_week_nxt = 8'(in_digit_c) * 8'd10 + 8'(in_digit_d);
      s1_day_nxt  = in_digit_e;
    end else begin
      s1_week_nxt = 8'(in_digit_c);
      s1_day_nxt  = in_digit_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_ok_r   <= s1_ok_nxt;
      s1_yc_r   <= s1_yc_nxt;
      s1_week_r <= s1_week_nxt;
      s1_day_r  <= s1_day_nxt;
    end
  end

  // Map the year code onto the base year; start the weekday sum
  always_comb begin
    if (s1_yc_r > 8'(fwdc_pkg::PIVOT)) begin
      s2_yidx_nxt = 7'(s1_yc_r - 8'(fwdc_pkg::YEAR_BASE - fwdc_pkg::CENT_LO));
    end else begin
      s2_yidx_nxt = 7'(s1_yc_r + 8'(fwdc_pkg::CENT_HI - fwdc_pkg::YEAR_BASE));
    end
    // each year moves July 1 one weekday on, each leap day one more
    s2_wsum_nxt = 7'(fwdc_pkg::BASE_WD) + s2_yidx_nxt + {2'b00, s2_yidx_nxt[6:2]};
    s2_rel_nxt  = 11'(s1_week_r) * 11'd7 + 11'(s1_day_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_ok_r   <= s1_ok_r;
      s2_yidx_r <= s2_yidx_nxt;
      s2_wsum_r <= s2_wsum_nxt;
      s2_rel_r  <= s2_rel_nxt;
    end
  end

  // Advance July 1 to the first Saturday; count days from March 1
  always_comb begin
    wd  = fwdc_pkg::mod7(s2_wsum_r);
    adj = (wd == 3'(fwdc_pkg::SUN)) ? 3'(fwdc_pkg::SUN) : (3'(fwdc_pkg::SAT) - wd);
    s3_span_nxt.len_ok = s2_ok_r;
    s3_span_nxt.yidx   = s2_yidx_r;
    // week and day each count from one, hence the eight days taken off
    s3_span_nxt.dnum   = s2_rel_r + 11'(adj) + 11'(fwdc_pkg::MAR_TO_JUL - 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_span_r <= s3_span_nxt;
    end
  end

  // Day number to calendar date, with the output register
  fwdc_date_conv u_conv (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (s3_v_r),
    .in_ready      (conv_rdy),
    .in_span       (s3_span_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_valid_res (out_valid_res),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day)
  );

endmodule

FILE: rtl/fwdc_checker.sv
// ----------------------------------------------------------------------------
// Fiscal week date code decoder checker
// Watches the result port for date ranges, the bad-length word and holds.
// ----------------------------------------------------------------------------
`include "fiscal_week_date_code_decoder_assert.svh"

module fwdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_valid_res,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day
);

  // A decoded date has a real month and day
  `FWDC_ASSERT_HOLDS(a_date_range, out_valid && out_valid_res, out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1)

  // February never runs past the 29th
  `FWDC_ASSERT_HOLDS(a_feb_len, out_valid && out_valid_res && out_month == 4'd2, out_day <= 5'd29)

  // Decoded years stay inside the span the codes can reach
  `FWDC_ASSERT_HOLDS(a_year_range, out_valid && out_valid_res, out_year >= 12'd1980 && out_year <= 12'd2083)

  // A bad length yields an all-zero word
  `FWDC_ASSERT_HOLDS(a_bad_len_zero, out_valid && !out_valid_res, out_year == 12'd0 && out_month == 4'd0 && out_day == 5'd0)

  // A stalled result holds
  `FWDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_valid_res) && $stable(out_year) && $stable(out_month) && $stable(out_day))

endmodule

bind fiscal_week_date_code_decoder fwdc_checker u_fwdc_checker (.*);
